// File: hw/rtl/wscp_pkg.sv
// ----------------------------------------------------------------------------
// wscp_pkg
// Shared widths, command and register codes, and the control/status types
// that join the controller and the datapath of the state counter pacer.
// ----------------------------------------------------------------------------
package wscp_pkg;

    localparam int STATE_WIDTH   = 16;
    localparam int N_WIDTH       = STATE_WIDTH + 1;
    localparam int WORD_WIDTH    = 32;
    localparam int DVD_WIDTH     = WORD_WIDTH + 2;
    localparam int OVER_WIDTH    = WORD_WIDTH + 2;
    localparam int PERIOD_WIDTH  = 26;
    localparam int CAP_WIDTH     = PERIOD_WIDTH + 7;
    localparam int CMD_WIDTH     = 3;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int DIV_STEPS     = DVD_WIDTH;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
    localparam int LAG_FACTOR    = 100;

    localparam logic [WORD_WIDTH-1:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam logic [STATE_WIDTH-1:0]  RST_FIRST  = STATE_WIDTH'(1);
    localparam logic [STATE_WIDTH-1:0]  RST_LAST   = STATE_WIDTH'(10);
    localparam logic [PERIOD_WIDTH-1:0] RST_PERIOD = PERIOD_WIDTH'(100);

    localparam logic [CMD_WIDTH-1:0] CMD_BEGIN   = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_END     = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_ADD_CUR = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_ADD_GIV = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_SET     = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_DIFF    = 3'd5;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_FIRST  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LAST   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIOD = 2'd2;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_step;
        logic fix;
        logic late;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] cmd;
    } t_dp_stat;

endpackage

// File: hw/rtl/wscp_if.sv
// ----------------------------------------------------------------------------
// wscp interfaces
// Valid/ready channels of the state counter pacer: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface wscp_req_if import wscp_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [CMD_WIDTH-1:0]         command;
    logic signed [WORD_WIDTH-1:0] given_state;
    logic signed [WORD_WIDTH-1:0] step_count;
    logic [WORD_WIDTH-1:0]        now_ms;

    modport source (output valid, command, given_state, step_count, now_ms, input ready);
    modport sink   (input valid, command, given_state, step_count, now_ms, output ready);
endinterface

interface wscp_rsp_if import wscp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATE_WIDTH-1:0] current_state;
    logic [STATE_WIDTH-1:0] answer;
    logic [WORD_WIDTH-1:0]  elapsed_ms;
    logic [WORD_WIDTH-1:0]  lag_ms;
    logic                   is_late;
    logic [WORD_WIDTH-1:0]  resume_at_ms;

    modport source (output valid, current_state, answer, elapsed_ms, lag_ms, is_late,
                    resume_at_ms, input ready);
    modport sink   (input valid, current_state, answer, elapsed_ms, lag_ms, is_late,
                    resume_at_ms, output ready);
endinterface

interface wscp_cfg_if import wscp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] addr;
    logic [WORD_WIDTH-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: hw/rtl/wscp_rem.sv
// ----------------------------------------------------------------------------
// wscp_rem
// Bit-serial remainder unit: magnitude of a signed dividend modulo the
// range size, one dividend bit per step.
// ----------------------------------------------------------------------------
module wscp_rem import wscp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic                        i_step,
    input  logic signed [DVD_WIDTH-1:0] i_dividend,
    input  logic [N_WIDTH-1:0]          i_divisor,
    output logic [N_WIDTH-1:0]          o_rem,
    output logic                        o_neg
);

    logic [DVD_WIDTH-1:0] r_mag;
    logic [N_WIDTH-1:0]   r_rem;
    logic                 r_neg;
    logic [N_WIDTH:0]     w_trial;
    logic [N_WIDTH:0]     w_diff;

    assign w_trial = {r_rem, r_mag[DVD_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag <= i_dividend[DVD_WIDTH-1] ? DVD_WIDTH'(-i_dividend) : i_dividend;
            r_neg <= i_dividend[DVD_WIDTH-1];
            r_rem <= '0;
        end else if (i_step) begin
            r_mag <= {r_mag[DVD_WIDTH-2:0], 1'b0};
            // keep the partial remainder below the divisor
            if (w_trial >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[N_WIDTH-1:0];
            end else begin
                r_rem <= w_trial[N_WIDTH-1:0];
            end
        end
    end

    assign o_rem = r_rem;
    assign o_neg = r_neg;

endmodule

// File: hw/rtl/wscp_ctrl.sv
// ----------------------------------------------------------------------------
// wscp_ctrl
// Sequencer of the state counter pacer: takes a request, steps the datapath
// through its phases and hands the response to the output register.
// ----------------------------------------------------------------------------
module wscp_ctrl import wscp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_LATE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [DIV_CNT_WIDTH-1:0] r_cnt;
    logic [DIV_CNT_WIDTH-1:0] n_cnt;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic                     w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                if (i_stat.cmd == CMD_END) begin
                    n_state = S_LATE;
                end else if (i_stat.cmd inside {CMD_ADD_CUR, CMD_ADD_GIV, CMD_SET, CMD_DIFF}) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_WIDTH'(DIV_STEPS - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DONE;
            end
            S_LATE: begin
                o_cmd.late = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                o_cmd.commit = w_slot_free;
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/wscp_dp.sv
// ----------------------------------------------------------------------------
// wscp_dp
// Datapath of the state counter pacer: configuration registers, counter,
// timing state, range wrap through the remainder unit, response register.
// ----------------------------------------------------------------------------
module wscp_dp import wscp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_stat                     o_stat,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]     i_cfg_addr,
    input  logic [WORD_WIDTH-1:0]        i_cfg_data,
    input  logic [CMD_WIDTH-1:0]         i_command,
    input  logic signed [WORD_WIDTH-1:0] i_given_state,
    input  logic signed [WORD_WIDTH-1:0] i_step_count,
    input  logic [WORD_WIDTH-1:0]        i_now_ms,
    output logic [STATE_WIDTH-1:0]       o_current_state,
    output logic [STATE_WIDTH-1:0]       o_answer,
    output logic [WORD_WIDTH-1:0]        o_elapsed_ms,
    output logic [WORD_WIDTH-1:0]        o_lag_ms,
    output logic                         o_is_late,
    output logic [WORD_WIDTH-1:0]        o_resume_at_ms
);

    // configuration and block state
    logic [STATE_WIDTH-1:0]  r_first;
    logic [STATE_WIDTH-1:0]  r_last;
    logic [PERIOD_WIDTH-1:0] r_period;
    logic [STATE_WIDTH-1:0]  r_counter;
    logic [WORD_WIDTH-1:0]   r_begin;
    logic [WORD_WIDTH-1:0]   r_lag;

    // captured request
    logic [CMD_WIDTH-1:0]         r_cmd;
    logic signed [WORD_WIDTH-1:0] r_given;
    logic signed [WORD_WIDTH-1:0] r_count;
    logic [WORD_WIDTH-1:0]        r_now;

    // intermediate results
    logic [WORD_WIDTH-1:0]  r_elapsed;
    logic [WORD_WIDTH-1:0]  r_cap;
    logic [OVER_WIDTH-1:0]  r_over;
    logic [STATE_WIDTH-1:0] r_wrap;

    // response register
    logic [STATE_WIDTH-1:0] r_o_state;
    logic [STATE_WIDTH-1:0] r_o_answer;
    logic [WORD_WIDTH-1:0]  r_o_elapsed;
    logic [WORD_WIDTH-1:0]  r_o_lag;
    logic                   r_o_late;
    logic [WORD_WIDTH-1:0]  r_o_resume;

    logic [N_WIDTH-1:0]          w_n;
    logic signed [DVD_WIDTH-1:0] w_base;
    logic signed [DVD_WIDTH-1:0] w_add;
    logic signed [DVD_WIDTH-1:0] w_dvd;
    logic [CAP_WIDTH-1:0]        w_cap_full;
    logic [N_WIDTH-1:0]          w_rem;
    logic                        w_neg;
    logic [N_WIDTH-1:0]          w_adj;
    logic [N_WIDTH-1:0]          w_diff;
    logic [N_WIDTH-1:0]          w_dist;
    logic                        w_late;
    logic [WORD_WIDTH-1:0]       w_late_lag;
    logic [STATE_WIDTH-1:0]      w_cfg_state;

    logic [STATE_WIDTH-1:0] n_counter;
    logic [WORD_WIDTH-1:0]  n_lag;
    logic [WORD_WIDTH-1:0]  n_begin;
    logic [STATE_WIDTH-1:0] n_answer;
    logic [WORD_WIDTH-1:0]  n_elapsed;
    logic [WORD_WIDTH-1:0]  n_resume;

    assign w_n = {1'b0, r_last} - {1'b0, r_first} + N_WIDTH'(1);

    // offset of the value to wrap, relative to the first state
    always_comb begin
        if (r_cmd == CMD_ADD_CUR) begin
            w_base = {{(DVD_WIDTH - STATE_WIDTH){1'b0}}, r_counter};
        end else begin
            w_base = {{(DVD_WIDTH - WORD_WIDTH){r_given[WORD_WIDTH-1]}}, r_given};
        end
        if (r_cmd == CMD_ADD_CUR || r_cmd == CMD_ADD_GIV) begin
            w_add = {{(DVD_WIDTH - WORD_WIDTH){r_count[WORD_WIDTH-1]}}, r_count};
        end else begin
            w_add = '0;
        end
        w_dvd = w_base + w_add - {{(DVD_WIDTH - STATE_WIDTH){1'b0}}, r_first};
    end

    wscp_rem u_rem (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_dvd),
        .i_divisor  (w_n),
        .o_rem      (w_rem),
        .o_neg      (w_neg)
    );

    assign w_cap_full = CAP_WIDTH'(r_period) * CAP_WIDTH'(LAG_FACTOR);
    assign w_adj      = (w_neg && w_rem != '0) ? (w_n - w_rem) : w_rem;

    // forward distance, wrapped by the range size
    assign w_diff = {1'b0, r_counter} - {1'b0, r_wrap};
    assign w_dist = w_diff[N_WIDTH-1] ? (w_diff + w_n) : w_diff;

    // late when elapsed + lag - period is above zero
    assign w_late     = !r_over[OVER_WIDTH-1] && (r_over != '0);
    assign w_late_lag = (r_over > {{(OVER_WIDTH - WORD_WIDTH){1'b0}}, r_cap})
                        ? r_cap : r_over[WORD_WIDTH-1:0];

    always_comb begin
        n_counter = r_counter;
        n_lag     = r_lag;
        n_begin   = r_begin;
        n_answer  = '0;
        n_elapsed = '0;
        n_resume  = '0;
        case (r_cmd)
            CMD_BEGIN: begin
                n_begin = r_now;
            end
            CMD_END: begin
                n_counter = (r_counter == r_last) ? r_first : r_counter + 1'b1;
                n_elapsed = r_elapsed;
                n_lag     = w_late ? w_late_lag : '0;
                n_resume  = w_late ? r_now : r_now + WORD_WIDTH'(r_period);
            end
            CMD_ADD_CUR, CMD_ADD_GIV: begin
                n_answer = r_wrap;
            end
            CMD_SET: begin
                n_counter = r_wrap;
            end
            CMD_DIFF: begin
                n_answer = w_dist[STATE_WIDTH-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_cfg_state = i_cfg_data[STATE_WIDTH-1:0];

    // block state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= RST_FIRST;
            r_last    <= RST_LAST;
            r_period  <= RST_PERIOD;
            r_counter <= RST_FIRST;
            r_begin   <= '0;
            r_lag     <= '0;
        end else if (i_cmd.commit) begin
            r_counter <= n_counter;
            r_lag     <= n_lag;
            r_begin   <= n_begin;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FIRST: begin
                    if (w_cfg_state <= r_last) begin
                        r_first <= w_cfg_state;
                        if (r_counter < w_cfg_state) begin
                            r_counter <= w_cfg_state;
                        end
                    end
                end
                REG_LAST: begin
                    if (w_cfg_state >= r_first) begin
                        r_last <= w_cfg_state;
                        if (r_counter > w_cfg_state) begin
                            r_counter <= w_cfg_state;
                        end
                    end
                end
                REG_PERIOD: begin
                    r_period <= i_cfg_data[PERIOD_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // request capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= i_command;
            r_given <= i_given_state;
            r_count <= i_step_count;
            r_now   <= i_now_ms;
        end
        if (i_cmd.prep) begin
            r_elapsed <= r_now - r_begin;
            r_cap     <= (w_cap_full > CAP_WIDTH'(WORD_MAX)) ? WORD_MAX
                                                            : w_cap_full[WORD_WIDTH-1:0];
        end
        if (i_cmd.late) begin
            r_over <= {{(OVER_WIDTH - WORD_WIDTH){1'b0}}, r_elapsed}
                    + {{(OVER_WIDTH - WORD_WIDTH){1'b0}}, r_lag}
                    - {{(OVER_WIDTH - PERIOD_WIDTH){1'b0}}, r_period};
        end
        if (i_cmd.fix) begin
            r_wrap <= r_first + w_adj[STATE_WIDTH-1:0];
        end
        if (i_cmd.commit) begin
            r_o_state   <= n_counter;
            r_o_answer  <= n_answer;
            r_o_elapsed <= n_elapsed;
            r_o_lag     <= n_lag;
            r_o_late    <= (n_lag != '0);
            r_o_resume  <= n_resume;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_current_state = r_o_state;
    assign o_answer        = r_o_answer;
    assign o_elapsed_ms    = r_o_elapsed;
    assign o_lag_ms        = r_o_lag;
    assign o_is_late       = r_o_late;
    assign o_resume_at_ms  = r_o_resume;

endmodule

// File: hw/rtl/wrapping_state_counter_pacer_core.sv
// ----------------------------------------------------------------------------
// wrapping_state_counter_pacer_core
// State counter that wraps between configured bounds and paces each state,
// tracking accumulated lateness.
// ----------------------------------------------------------------------------
// One request in, one response out. Requests are taken one at a time: begin
// runs a prepare and a done step, end adds a lateness step, and add_current,
// add_given, set_state and diff add a fix step after the bit-serial remainder
// unit wraps a value into the range, one bit of a 34-bit dividend per cycle.
// The response sits in an output register, so a new request is accepted while
// the previous response waits; a finished request waits in its last step only
// if that register is still full. Configuration writes are always ready and
// take effect on the edge they are accepted, unless a response commits on it;
// write them only while no request is in flight. A bound write that would
// cross the other bound is dropped, and one inside range clamps the counter.
// Unknown commands report the state with answer, elapsed and resume at zero.
module wrapping_state_counter_pacer_core import wscp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wscp_cfg_if.sink    i_cfg,
    wscp_req_if.sink    i_req,
    wscp_rsp_if.source  o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_cfg_we;

    // configuration is always taken
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    wscp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    wscp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_addr      (i_cfg.addr),
        .i_cfg_data      (i_cfg.data),
        .i_command       (i_req.command),
        .i_given_state   (i_req.given_state),
        .i_step_count    (i_req.step_count),
        .i_now_ms        (i_req.now_ms),
        .o_current_state (o_rsp.current_state),
        .o_answer        (o_rsp.answer),
        .o_elapsed_ms    (o_rsp.elapsed_ms),
        .o_lag_ms        (o_rsp.lag_ms),
        .o_is_late       (o_rsp.is_late),
        .o_resume_at_ms  (o_rsp.resume_at_ms)
    );

endmodule

// File: hw/rtl/wscp_chk.sv
// ----------------------------------------------------------------------------
// wscp_chk
// Port-level checks of the state counter pacer, bound to the top level.
// ----------------------------------------------------------------------------
module wscp_chk import wscp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_req_valid,
    input logic                   i_req_ready,
    input logic                   i_rsp_valid,
    input logic                   i_rsp_ready,
    input logic [STATE_WIDTH-1:0] i_rsp_state,
    input logic [STATE_WIDTH-1:0] i_rsp_answer,
    input logic [WORD_WIDTH-1:0]  i_rsp_lag,
    input logic                   i_rsp_late,
    input logic [WORD_WIDTH-1:0]  i_rsp_resume
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_state) && $stable(i_rsp_answer)
            && $stable(i_rsp_lag) && $stable(i_rsp_resume))
        else $error("response changed while stalled");

    a_late_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_late == (i_rsp_lag != '0)))
        else $error("late flag disagrees with lag");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

endmodule

bind wrapping_state_counter_pacer_core wscp_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_state  (o_rsp.current_state),
    .i_rsp_answer (o_rsp.answer),
    .i_rsp_lag    (o_rsp.lag_ms),
    .i_rsp_late   (o_rsp.is_late),
    .i_rsp_resume (o_rsp.resume_at_ms)
);
